// ----- src/pitp_pkg.sv -----
// Package for the point-in-transformed-polygon unit.
// Holds register indexes, operation codes, controller/datapath structs and
// the 32-bit saturation helper. No dependencies.
package pitp_pkg;

   localparam logic [2:0] REG_VERTEX_COUNT = 3'd0;
   localparam logic [2:0] REG_OFFSET_X     = 3'd1;
   localparam logic [2:0] REG_OFFSET_Y     = 3'd2;
   localparam logic [2:0] REG_SCALE_X      = 3'd3;
   localparam logic [2:0] REG_SCALE_Y      = 3'd4;
   localparam logic [2:0] REG_ROT_COS      = 3'd5;
   localparam logic [2:0] REG_ROT_SIN      = 3'd6;

   localparam logic OP_WRITE_VERTEX = 1'b0;
   localparam logic OP_TEST_POINT   = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic wr_vertex;  // store request coordinates in vertex memory
      logic start;      // latch query point, clear counters
      logic rd;         // read vertex k
      logic scale;      // per-axis scale products
      logic rot;        // rotation products
      logic sum;        // combine, offset, saturate
      logic inc;        // advance vertex index
      logic edge_chk;   // edge products and range test
      logic final_edge; // closing edge uses the first vertex
      logic cmp;        // decide crossing, accumulate
      logic load_zero;  // result of zeros
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic n_zero;
      logic first;
      logic last;
   } sts_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      logic signed [31:0] r;
      if (v > 48'sd2147483647) r = 32'sh7FFFFFFF;
      else if (v < -48'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction

endpackage

// ----- src/pitp_ctrl.sv -----
// Controller state machine of the point-in-transformed-polygon unit.
// Sequences vertex reads, transform steps and edge tests. Uses pitp_pkg.
module pitp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_operation,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  pitp_pkg::sts_type sts,
   output pitp_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_READ  = 3'd1;
   localparam logic [2:0] ST_SCALE = 3'd2;
   localparam logic [2:0] ST_ROT   = 3'd3;
   localparam logic [2:0] ST_SUM   = 3'd4;
   localparam logic [2:0] ST_EDGE  = 3'd5;
   localparam logic [2:0] ST_CMP   = 3'd6;
   localparam logic [2:0] ST_RESP  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       final_ff, final_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

   always_comb begin
      state_in = state_ff;
      final_in = final_ff;
      cmd      = '0;
      cmd.final_edge = final_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == pitp_pkg::OP_WRITE_VERTEX) begin
                  cmd.wr_vertex = 1'b1;
                  cmd.load_zero = 1'b1;
                  state_in      = ST_RESP;
               end else begin
                  cmd.start = 1'b1;
                  final_in  = 1'b0;
                  if (sts.n_zero) begin
                     cmd.load_zero = 1'b1;
                     state_in      = ST_RESP;
                  end else begin
                     state_in = ST_READ;
                  end
               end
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = ST_ROT;
         end
         ST_ROT: begin
            cmd.rot  = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
            if (sts.first) begin
               // first vertex opens the chain; only a single-vertex polygon goes on to the closing edge
               if (sts.last) begin
                  final_in = 1'b1;
                  state_in = ST_EDGE;
               end else begin
                  cmd.inc  = 1'b1;
                  state_in = ST_READ;
               end
            end else begin
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            cmd.edge_chk = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            cmd.cmp = 1'b1;
            if (final_ff) begin
               state_in = ST_RESP;
            end else if (sts.last) begin
               final_in = 1'b1;
               state_in = ST_EDGE;
            end else begin
               cmd.inc  = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         final_ff <= final_in;
      end
   end

   a_resp_release: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && !rsp_stall) |=> (state_ff == ST_IDLE))
      else $error("result not released after transaction");

   a_edge_then_cmp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EDGE) |=> (state_ff == ST_CMP && $stable(final_ff)))
      else $error("edge test not followed by compare");

endmodule

// ----- src/pitp_dp.sv -----
// Datapath of the point-in-transformed-polygon unit: configuration
// registers, vertex memory, transform arithmetic and crossing counter.
// Uses pitp_pkg; driven by pitp_ctrl commands.
module pitp_dp #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_wdata,
   input  logic [5:0]               req_vertex_index,
   input  logic signed [31:0]       req_coord_x,
   input  logic signed [31:0]       req_coord_y,
   input  pitp_pkg::cmd_type        cmd,
   output pitp_pkg::sts_type        sts,
   output logic                     rsp_inside_res,
   output logic [6:0]               rsp_crossing_count
);

   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   // configuration
   logic [6:0]         vcount_ff;
   logic signed [31:0] off_x_ff, off_y_ff;
   logic signed [23:0] scl_x_ff, scl_y_ff;
   logic signed [17:0] cos_ff, sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= '0;
         off_x_ff  <= '0;
         off_y_ff  <= '0;
         scl_x_ff  <= 24'sd65536;
         scl_y_ff  <= 24'sd65536;
         cos_ff    <= 18'sd65536;
         sin_ff    <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            pitp_pkg::REG_VERTEX_COUNT: vcount_ff <= csr_wdata[6:0];
            pitp_pkg::REG_OFFSET_X:     off_x_ff  <= csr_wdata;
            pitp_pkg::REG_OFFSET_Y:     off_y_ff  <= csr_wdata;
            pitp_pkg::REG_SCALE_X:      scl_x_ff  <= csr_wdata[23:0];
            pitp_pkg::REG_SCALE_Y:      scl_y_ff  <= csr_wdata[23:0];
            pitp_pkg::REG_ROT_COS:      cos_ff    <= csr_wdata[17:0];
            pitp_pkg::REG_ROT_SIN:      sin_ff    <= csr_wdata[17:0];
            default: ;
         endcase
      end
   end

   // vertex count clipped to capacity
   logic [CW-1:0] n_w;
   assign n_w = (32'(vcount_ff) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : CW'(vcount_ff);

   logic [CW-1:0] k_ff;
   assign sts.n_zero = (n_w == '0);
   assign sts.first  = (k_ff == '0);
   assign sts.last   = ((CW+1)'(k_ff) + (CW+1)'(1)) == (CW+1)'(n_w);

   // vertex memory, {x, y}
   logic [63:0] mem [MAX_VERTICES];
   logic [63:0] rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_vertex && (32'(req_vertex_index) < 32'(MAX_VERTICES)))
         mem[AW'(req_vertex_index)] <= {req_coord_x, req_coord_y};
      if (cmd.rd) rd_ff <= mem[k_ff[AW-1:0]];
   end

   logic signed [31:0] rd_x, rd_y;
   assign rd_x = rd_ff[63:32];
   assign rd_y = rd_ff[31:0];

   // scale
   logic signed [55:0] smx_ff, smy_ff;
   always_ff @(posedge clock) begin
      if (cmd.scale) begin
         smx_ff <= 56'(rd_x) * 56'(scl_x_ff);
         smy_ff <= 56'(rd_y) * 56'(scl_y_ff);
      end
   end

   // rotation
   logic signed [31:0] sx_w, sy_w;
   logic signed [49:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;
   assign sx_w = pitp_pkg::sat32(48'(smx_ff >>> 16));
   assign sy_w = pitp_pkg::sat32(48'(smy_ff >>> 16));

   always_ff @(posedge clock) begin
      if (cmd.rot) begin
         p_cx_ff <= 50'(cos_ff) * 50'(sx_w);
         p_sy_ff <= 50'(sin_ff) * 50'(sy_w);
         p_sx_ff <= 50'(sin_ff) * 50'(sx_w);
         p_cy_ff <= 50'(cos_ff) * 50'(sy_w);
      end
   end

   // combine, offset
   logic signed [50:0] rxw, ryw;
   logic signed [31:0] rx_w, ry_w, tx_w, ty_w;
   assign rxw  = 51'(p_cx_ff) - 51'(p_sy_ff);
   assign ryw  = 51'(p_sx_ff) + 51'(p_cy_ff);
   assign rx_w = pitp_pkg::sat32(48'(rxw >>> 16));
   assign ry_w = pitp_pkg::sat32(48'(ryw >>> 16));
   assign tx_w = pitp_pkg::sat32(48'(rx_w) + 48'(off_x_ff));
   assign ty_w = pitp_pkg::sat32(48'(ry_w) + 48'(off_y_ff));

   logic signed [31:0] tx_ff, ty_ff, fx_ff, fy_ff, prvx_ff, prvy_ff, curx_ff, cury_ff;
   logic signed [31:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         px_ff <= req_coord_x;
         py_ff <= req_coord_y;
      end
      if (cmd.sum) begin
         tx_ff <= tx_w;
         ty_ff <= ty_w;
         if (sts.first) begin
            fx_ff   <= tx_w;
            fy_ff   <= ty_w;
            prvx_ff <= tx_w;
            prvy_ff <= ty_w;
         end
      end
      if (cmd.cmp) begin
         prvx_ff <= curx_ff;
         prvy_ff <= cury_ff;
      end
   end

   // edge test: products of the cross-multiplied comparison
   logic signed [31:0] ex_w, ey_w;
   logic signed [32:0] a_w, dy_w, c_w, d_w;
   logic signed [65:0] m1_ff, m2_ff;
   logic               inr_ff, dypos_ff, dyneg_ff;
   assign ex_w = cmd.final_edge ? fx_ff : tx_ff;
   assign ey_w = cmd.final_edge ? fy_ff : ty_ff;
   assign a_w  = 33'(px_ff) - 33'(prvx_ff);
   assign dy_w = 33'(ey_w) - 33'(prvy_ff);
   assign c_w  = 33'(ex_w) - 33'(prvx_ff);
   assign d_w  = 33'(py_ff) - 33'(prvy_ff);

   always_ff @(posedge clock) begin
      if (cmd.edge_chk) begin
         curx_ff  <= ex_w;
         cury_ff  <= ey_w;
         m1_ff    <= 66'(a_w) * 66'(dy_w);
         m2_ff    <= 66'(c_w) * 66'(d_w);
         inr_ff   <= ((prvy_ff <= py_ff) && (py_ff < ey_w)) ||
                     ((ey_w <= py_ff) && (py_ff < prvy_ff));
         dypos_ff <= (dy_w > 33'sd0);
         dyneg_ff <= (dy_w < 33'sd0);
      end
   end

   logic signed [66:0] diff_w;
   logic               hit_w;
   logic [CW-1:0]      cnt_ff, cnt_in;
   assign diff_w = 67'(m1_ff) - 67'(m2_ff);
   // horizontal edges have neither sign and never count
   assign hit_w  = inr_ff && ((dypos_ff && (diff_w < 67'sd0)) ||
                              (dyneg_ff && (diff_w > 67'sd0)));
   assign cnt_in = cnt_ff + CW'(hit_w);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= '0;
         cnt_ff <= '0;
      end else begin
         if (cmd.start) begin
            k_ff   <= '0;
            cnt_ff <= '0;
         end else begin
            if (cmd.inc) k_ff <= k_ff + CW'(1);
            if (cmd.cmp) cnt_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_zero) begin
         rsp_inside_res     <= 1'b0;
         rsp_crossing_count <= '0;
      end else if (cmd.cmp && cmd.final_edge) begin
         rsp_inside_res     <= cnt_in[0];
         rsp_crossing_count <= 7'(cnt_in);
      end
   end

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd |-> (k_ff < n_w))
      else $error("vertex read past vertex count");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.cmp |-> ((CW+1)'(cnt_ff) < (CW+1)'(n_w) + (CW+1)'(1)))
      else $error("crossing count exceeds edge count");

endmodule

// ----- src/point_in_transformed_polygon_unit.sv -----
// Point-in-polygon tester over a transformed polygon of up to MAX_VERTICES
// vertices (even-odd rule). A vertex write returns one zero result in the cycle
// after it is accepted. A point test walks the polygon one vertex at a time
// through a single shared transform and edge datapath. Each vertex goes through
// read, scale, rotate and offset steps, and each edge then through edge and
// compare steps for the cross-multiplied test. The result is held while it is
// stalled. Only one transaction is in flight at a time.
// Top level; uses pitp_pkg, pitp_ctrl and pitp_dp.
module point_in_transformed_polygon_unit #(
   parameter int MAX_VERTICES = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [5:0]         req_vertex_index,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_inside_res,
   output logic [6:0]         rsp_crossing_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   pitp_pkg::cmd_type cmd;
   pitp_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   pitp_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .sts           (sts),
      .cmd           (cmd)
   );

   pitp_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_vertex_index   (req_vertex_index),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_inside_res     (rsp_inside_res),
      .rsp_crossing_count (rsp_crossing_count)
   );

endmodule
